// ===== src/xrd_pkg.sv =====
// Shared types, constants and a helper function for the xorshift random draw unit.
`default_nettype none

package xrd_pkg;

    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W    = 3;
    localparam int DIV_STEPS = 31;
    localparam int JOB_QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_C = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_D = 2'd3;

    localparam logic [WORD_W-1:0] INIT_A_RESET = 32'd123456789;
    localparam logic [WORD_W-1:0] INIT_B_RESET = 32'd362436069;
    localparam logic [WORD_W-1:0] INIT_C_RESET = 32'd521288629;
    localparam logic [WORD_W-1:0] INIT_D_RESET = 32'd88675123;

    localparam logic CMD_RESEED = 1'b0;
    localparam logic CMD_DRAW   = 1'b1;

    localparam int SHIFT_A      = 11;
    localparam int SHIFT_D      = 19;
    localparam int SHIFT_T      = 8;
    localparam int SEED_SHL_B   = 17;
    localparam int SEED_SHL_C   = 31;
    localparam int SEED_SHL_D   = 18;
    localparam int SEED_SHR_B   = 15;
    localparam int SEED_SHR_C   = 1;
    localparam int SEED_SHR_D   = 14;
    localparam logic [WORD_W-1:0] BOOL_MASK = 32'h0000_0001;
    localparam logic [63:0] MASK31 = 64'h0000_0000_7FFF_FFFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_WORD  = 3'd0,
        MODE_LOW31 = 3'd1,
        MODE_MOD   = 3'd2,
        MODE_RANGE = 3'd3,
        MODE_BOOL  = 3'd4
    } draw_mode_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_DIV  = 2'd1,
        BK_DONE = 2'd2
    } back_state_t;

    typedef struct packed {
        logic                needs_div;
        logic [WORD_W-1:0]   base_value;
        logic [WORD_W-2:0]   dividend;
        logic [WORD_W:0]     divisor;
        logic [WORD_W-1:0]   seed;
        logic                bad;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [63:0] sext64(input logic [WORD_W-1:0] v);
        sext64 = {{(64 - WORD_W){v[WORD_W-1]}}, v};
    endfunction

endpackage

`default_nettype wire

// ===== src/xrd_front.sv =====
// Front end: configuration registers, generator state, and job classification.
`default_nettype none

module xrd_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [xrd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [xrd_pkg::WORD_W-1:0]        cfg_data,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic                              cmd,
    input  wire logic [xrd_pkg::MODE_W-1:0]        draw_mode,
    input  wire logic signed [xrd_pkg::WORD_W-1:0] seed_value,
    input  wire logic signed [xrd_pkg::WORD_W-1:0] draw_bound,
    input  wire logic signed [xrd_pkg::WORD_W-1:0] range_low,
    input  wire logic signed [xrd_pkg::WORD_W-1:0] range_high,
    input  wire xrd_pkg::queue_status_t            queue_status,
    output logic                                   job_push,
    output xrd_pkg::job_t                          job
);
    import xrd_pkg::*;

    logic [WORD_W-1:0] init_a_reg, init_b_reg, init_c_reg, init_d_reg;
    logic [WORD_W-1:0] word_a_reg, word_b_reg, word_c_reg, word_d_reg;
    logic              word_d_hi_reg;
    logic [WORD_W-1:0] seed_reg;

    logic [WORD_W-1:0] word_a_next, word_b_next, word_c_next, word_d_next;
    logic              word_d_hi_next;
    logic [WORD_W-1:0] seed_next;

    logic [63:0]       sx, mix_b, mix_c, mix_d, d_full, d_shift;
    logic [WORD_W-1:0] s, t, t_shift, new_d;
    logic [WORD_W+1:0] span;

    assign full     = queue_status.full;
    assign job_push = push && !queue_status.full;

    always_comb
    begin
        s       = seed_value;
        sx      = sext64(s);
        mix_b   = ({32'd0, init_b_reg} ^ sext64(s << SEED_SHL_B)) | ((sx >> SEED_SHR_B) & MASK31);
        mix_c   = ({32'd0, init_c_reg} ^ sext64(s << SEED_SHL_C)) | ((sx >> SEED_SHR_C) & MASK31);
        mix_d   = ({32'd0, init_d_reg} ^ sext64(s << SEED_SHL_D)) | ((sx >> SEED_SHR_D) & MASK31);

        t       = word_a_reg ^ (word_a_reg << SHIFT_A);
        t_shift = t >> SHIFT_T;
        d_full  = {{(64 - WORD_W){word_d_hi_reg}}, word_d_reg};
        d_shift = (d_full >> SHIFT_D) & MASK31;
        new_d   = word_d_reg ^ d_shift[WORD_W-1:0] ^ t ^ t_shift;

        span    = {{2{range_high[WORD_W-1]}}, range_high} + (WORD_W+2)'(1)
                  - {{2{range_low[WORD_W-1]}}, range_low};
    end

    always_comb
    begin
        word_a_next    = word_a_reg;
        word_b_next    = word_b_reg;
        word_c_next    = word_c_reg;
        word_d_next    = word_d_reg;
        word_d_hi_next = word_d_hi_reg;
        seed_next      = seed_reg;

        job.needs_div  = 1'b0;
        job.base_value = '0;
        job.dividend   = new_d[WORD_W-2:0];
        job.divisor    = {1'b0, draw_bound};
        job.bad        = 1'b0;

        if (cmd == CMD_RESEED)
        begin
            seed_next      = s;
            word_a_next    = init_a_reg ^ s;
            word_b_next    = mix_b[WORD_W-1:0];
            word_c_next    = mix_c[WORD_W-1:0];
            word_d_next    = mix_d[WORD_W-1:0];
            word_d_hi_next = mix_d[WORD_W];
        end
        else
        begin
            word_a_next    = word_b_reg;
            word_b_next    = word_c_reg;
            word_c_next    = word_d_reg;
            word_d_next    = new_d;
            word_d_hi_next = 1'b0;
            case (draw_mode)
                MODE_WORD:
                begin
                    job.base_value = new_d;
                end
                MODE_LOW31:
                begin
                    job.base_value = {1'b0, new_d[WORD_W-2:0]};
                end
                MODE_MOD:
                begin
                    if (draw_bound[WORD_W-1] || draw_bound == '0)
                    begin
                        job.bad = 1'b1;
                    end
                    else
                    begin
                        job.needs_div = 1'b1;
                    end
                end
                MODE_RANGE:
                begin
                    if (span[WORD_W+1] || span == '0)
                    begin
                        job.bad = 1'b1;
                    end
                    else
                    begin
                        job.needs_div  = 1'b1;
                        job.divisor    = span[WORD_W:0];
                        job.base_value = range_low;
                    end
                end
                MODE_BOOL:
                begin
                    job.base_value = ((new_d & BOOL_MASK) == '0) ? BOOL_MASK : '0;
                end
                default:
                begin
                    job.base_value = '0;
                end
            endcase
        end
        job.seed = seed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_a_reg    <= INIT_A_RESET;
            init_b_reg    <= INIT_B_RESET;
            init_c_reg    <= INIT_C_RESET;
            init_d_reg    <= INIT_D_RESET;
            word_a_reg    <= INIT_A_RESET;
            word_b_reg    <= INIT_B_RESET;
            word_c_reg    <= INIT_C_RESET;
            word_d_reg    <= INIT_D_RESET;
            word_d_hi_reg <= 1'b0;
            seed_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_INIT_A: init_a_reg <= cfg_data;
                    CFG_INIT_B: init_b_reg <= cfg_data;
                    CFG_INIT_C: init_c_reg <= cfg_data;
                    CFG_INIT_D: init_d_reg <= cfg_data;
                    default:    init_a_reg <= init_a_reg;
                endcase
            end
            if (job_push)
            begin
                word_a_reg    <= word_a_next;
                word_b_reg    <= word_b_next;
                word_c_reg    <= word_c_next;
                word_d_reg    <= word_d_next;
                word_d_hi_reg <= word_d_hi_next;
                seed_reg      <= seed_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/xrd_queue.sv =====
// Short job queue between the front end and the back end.
`default_nettype none

module xrd_queue #(
    parameter int DEPTH = xrd_pkg::JOB_QUEUE_DEPTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire xrd_pkg::job_t          push_job,
    input  wire logic                   pop,
    output xrd_pkg::job_t               head_job,
    output xrd_pkg::queue_status_t      status
);
    import xrd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== src/xrd_back.sv =====
// Back end: serial remainder unit and the result register.
`default_nettype none

module xrd_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire xrd_pkg::job_t                job,
    input  wire xrd_pkg::queue_status_t       queue_status,
    output logic                              job_pop,
    input  wire logic                         pop,
    output logic                              empty,
    output logic signed [xrd_pkg::WORD_W-1:0] value,
    output logic signed [xrd_pkg::WORD_W-1:0] current_seed,
    output logic                              bad_span
);
    import xrd_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    back_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  step_cnt_reg;
    logic              out_valid_reg;
    logic [WORD_W-2:0] rem_reg, dividend_reg;
    logic [WORD_W:0]   divisor_reg;
    logic [WORD_W-1:0] base_reg, seed_reg;
    logic [WORD_W-1:0] value_reg, current_seed_reg;
    logic              bad_reg;

    logic              out_free, take, load_direct, load_div, finish, last_step;
    logic [WORD_W-1:0] trial, trial_diff;
    logic [WORD_W-2:0] rem_step;

    assign out_free     = !out_valid_reg || pop;
    assign last_step    = (step_cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign empty        = !out_valid_reg;
    assign value        = value_reg;
    assign current_seed = current_seed_reg;
    assign bad_span     = bad_reg;

    always_comb
    begin
        trial      = {rem_reg, dividend_reg[WORD_W-2]};
        trial_diff = trial - divisor_reg[WORD_W-1:0];
        rem_step   = ({1'b0, trial} >= divisor_reg) ? trial_diff[WORD_W-2:0]
                                                     : trial[WORD_W-2:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!queue_status.empty && job.needs_div)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (last_step)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        take        = 1'b0;
        finish      = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                take = !queue_status.empty && (job.needs_div || out_free);
            end
            BK_DONE:
            begin
                finish = out_free;
            end
            default:
            begin
                take = 1'b0;
            end
        endcase
        job_pop     = take;
        load_direct = take && !job.needs_div;
        load_div    = take && job.needs_div;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_div)
            begin
                step_cnt_reg <= '0;
            end
            else if (state_reg == BK_DIV)
            begin
                step_cnt_reg <= step_cnt_reg + 1'b1;
            end
            if (load_direct || finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_div)
        begin
            rem_reg      <= '0;
            dividend_reg <= job.dividend;
            divisor_reg  <= job.divisor;
            base_reg     <= job.base_value;
            seed_reg     <= job.seed;
        end
        else if (state_reg == BK_DIV)
        begin
            rem_reg      <= rem_step;
            dividend_reg <= dividend_reg << 1;
        end
        if (load_direct)
        begin
            value_reg        <= job.base_value;
            current_seed_reg <= job.seed;
            bad_reg          <= job.bad;
        end
        else if (finish)
        begin
            value_reg        <= base_reg + {1'b0, rem_reg};
            current_seed_reg <= seed_reg;
            bad_reg          <= 1'b0;
        end
    end

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV || state_reg == BK_DONE) |-> ({2'b0, rem_reg} < divisor_reg))
        else $error("remainder is not below the divisor");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV && last_step) |=> (state_reg == BK_DONE))
        else $error("division did not end after the last step");

    a_bad_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bad_reg) |-> (value_reg == '0))
        else $error("flagged result carries a nonzero value");

    a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_IDLE) |-> !job_pop)
        else $error("job taken while the remainder unit is busy");

endmodule

`default_nettype wire

// ===== src/xorshift_random_draw_unit.sv =====
// Top level of the xorshift random draw unit.
//
// Items enter on a queue-style port: a transaction happens on a rising edge with push
// high and full low. Results leave the same way: while empty is low the oldest result
// is on value, current_seed and bad_span, and a transaction happens with pop high.
// Configuration writes on cfg_write/cfg_index/cfg_data take effect at the next reseed.
// The front end updates the generator state in the cycle an item is accepted and puts
// a job in a QUEUE_DEPTH-entry queue; the back end drains it in order.
// Reseeds and draws without a remainder are registered in the queue, then in the result
// register; they sustain one item per cycle while pop keeps up. Modulo and range draws
// with a valid bound or span hold the back end in a one-bit-per-cycle remainder unit.
// When pop stays low the result register holds, the back end stops, the queue fills
// and full rises. Reset restores the initial constants, the state and a zero seed,
// and empties the queue and the result register.
`default_nettype none

module xorshift_random_draw_unit #(
    parameter int QUEUE_DEPTH = xrd_pkg::JOB_QUEUE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [xrd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [xrd_pkg::WORD_W-1:0]        cfg_data,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic                              cmd,
    input  wire logic [xrd_pkg::MODE_W-1:0]        draw_mode,
    input  wire logic signed [xrd_pkg::WORD_W-1:0] seed_value,
    input  wire logic signed [xrd_pkg::WORD_W-1:0] draw_bound,
    input  wire logic signed [xrd_pkg::WORD_W-1:0] range_low,
    input  wire logic signed [xrd_pkg::WORD_W-1:0] range_high,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic signed [xrd_pkg::WORD_W-1:0]      value,
    output logic signed [xrd_pkg::WORD_W-1:0]      current_seed,
    output logic                                   bad_span
);
    import xrd_pkg::*;

    job_t          push_job, head_job;
    logic          job_push, job_pop;
    queue_status_t queue_status;

    xrd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .cmd          (cmd),
        .draw_mode    (draw_mode),
        .seed_value   (seed_value),
        .draw_bound   (draw_bound),
        .range_low    (range_low),
        .range_high   (range_high),
        .queue_status (queue_status),
        .job_push     (job_push),
        .job          (push_job)
    );

    xrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .head_job (head_job),
        .status   (queue_status)
    );

    xrd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (head_job),
        .queue_status (queue_status),
        .job_pop      (job_pop),
        .pop          (pop),
        .empty        (empty),
        .value        (value),
        .current_seed (current_seed),
        .bad_span     (bad_span)
    );

endmodule

`default_nettype wire
